/* sv/trle_pkg.sv */
// Shared types and constants for the transparent run-length encoder.
// Used by the interfaces and trle_* modules except trle_ram; no dependencies.
package trle_pkg;

    // Field widths
    localparam int PIXEL_W      = 8;
    localparam int PACK_W       = 64;
    localparam int BYTE_COUNT_W = 4;
    localparam int LIT_IDX_W    = 7;
    localparam int SKIP_W       = 8;

    // Run limits and packing
    localparam int MAX_LITERAL_RUN  = 127;
    localparam int MAX_SKIP_RUN     = 255;
    localparam int BYTES_PER_RESULT = 8;
    localparam int BYTE_LANES       = PACK_W / PIXEL_W;

    // Literal store: two banks, one per open or draining run
    localparam int BANK_DEPTH = 2 ** LIT_IDX_W;
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int RAM_ADDR_W = LIT_IDX_W + 1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    // Byte codes
    localparam logic [PIXEL_W-1:0] TRANSPARENT_PIXEL = 8'hFF;
    localparam logic [PIXEL_W-1:0] SKIP_CODE         = 8'h01;
    localparam logic [PIXEL_W-1:0] ROW_END_CODE      = 8'h00;

    // Everything one pixel asks of the back end
    typedef struct packed {
        logic                  skip_v;
        logic [SKIP_W-1:0]     skip_len;
        logic                  skip_first;
        logic                  lit_v;
        logic [LIT_IDX_W-1:0]  lit_cnt;
        logic                  lit_bank;
        logic                  row_end;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [RAM_ADDR_W-1:0] addr;
        logic [PIXEL_W-1:0]    data;
    } t_ram_wr;

    typedef struct packed {
        logic                  re;
        logic [RAM_ADDR_W-1:0] addr;
    } t_ram_rd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

    typedef struct packed {
        logic               valid;
        logic [PIXEL_W-1:0] value;
        logic               last;
    } t_byte;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SKIP_HDR,
        SEQ_SKIP_LEN,
        SEQ_LIT_CODE,
        SEQ_LIT_DATA,
        SEQ_ROW_END
    } t_seq_state;

endpackage

/* sv/trle_if.sv */
// Valid/ready channel interfaces: pixel input and packed word output.
// Depends on trle_pkg for field widths.
interface trle_pix_if;
    import trle_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;

    modport source (output valid, output pixel, output row_end, input ready);
    modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

interface trle_word_if;
    import trle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PACK_W-1:0]       packed_bytes;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    last;

    modport source (output valid, output packed_bytes, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input packed_bytes, input byte_count, input last,
                    output ready);
endinterface

/* sv/trle_ram.sv */
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module trle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/trle_front.sv */
// Front end: accepts pixels, tracks the open run, stores opaque pixels
// and issues one command per pixel that closes something. Uses trle_pkg, trle_pix_if.
module trle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    trle_pix_if.sink           i_pix,
    input  logic               i_cmdq_full,
    output logic               o_push,
    output trle_pkg::t_cmd     o_cmd,
    output trle_pkg::t_ram_wr  o_wr,
    input  trle_pkg::t_bank_rel i_rel
);
    import trle_pkg::*;

    logic [LIT_IDX_W-1:0] r_lc, n_lc;
    logic [SKIP_W-1:0]    r_sc, n_sc;
    logic                 r_in_skip, n_in_skip;
    logic                 r_wbank, n_wbank;
    logic [1:0]           r_busy, n_busy;

    logic                 accept;
    logic                 is_opaque;
    logic                 skip_close;
    logic [LIT_IDX_W:0]   lc_inc;
    logic [SKIP_W:0]      sc_inc;
    t_cmd                 cmd;

    // Stall while the queue is full or a new run would land in a draining bank
    assign i_pix.ready = !i_cmdq_full && !((r_lc == '0) && r_busy[r_wbank]);
    assign accept      = i_pix.valid && i_pix.ready;
    assign is_opaque   = (i_pix.pixel != TRANSPARENT_PIXEL);
    assign lc_inc      = {1'b0, r_lc} + (LIT_IDX_W+1)'(1);
    assign sc_inc      = {1'b0, r_sc} + (SKIP_W+1)'(1);

    // Classify the pixel and build its command
    always_comb begin
        cmd            = '0;
        cmd.lit_bank   = r_wbank;
        cmd.row_end    = i_pix.row_end;
        skip_close     = 1'b0;
        n_lc           = r_lc;
        n_sc           = r_sc;
        n_in_skip      = r_in_skip;
        if (is_opaque) begin
            cmd.skip_v     = r_in_skip;
            cmd.skip_len   = r_sc;
            cmd.skip_first = 1'b1;
            cmd.lit_v      = (lc_inc >= (LIT_IDX_W+1)'(MAX_LITERAL_RUN)) || i_pix.row_end;
            cmd.lit_cnt    = lc_inc[LIT_IDX_W-1:0];
            n_lc           = cmd.lit_v ? '0 : lc_inc[LIT_IDX_W-1:0];
            n_sc           = '0;
            n_in_skip      = 1'b0;
        end else begin
            skip_close     = (sc_inc >= (SKIP_W+1)'(MAX_SKIP_RUN)) || i_pix.row_end;
            cmd.lit_v      = (r_lc != '0);
            cmd.lit_cnt    = r_lc;
            cmd.skip_v     = skip_close;
            cmd.skip_len   = sc_inc[SKIP_W-1:0];
            n_lc           = '0;
            n_sc           = skip_close ? '0 : sc_inc[SKIP_W-1:0];
            n_in_skip      = !skip_close;
        end
    end

    // Bank ownership: claim on literal close, drop on release from the back end
    always_comb begin
        n_busy  = r_busy;
        n_wbank = r_wbank;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept && cmd.lit_v) begin
            n_busy[r_wbank] = 1'b1;
            n_wbank         = !r_wbank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc      <= '0;
            r_sc      <= '0;
            r_in_skip <= 1'b0;
            r_wbank   <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_busy  <= n_busy;
            r_wbank <= n_wbank;
            if (accept) begin
                r_lc      <= n_lc;
                r_sc      <= n_sc;
                r_in_skip <= n_in_skip;
            end
        end
    end

    assign o_push  = accept && (cmd.skip_v || cmd.lit_v || cmd.row_end);
    assign o_cmd   = cmd;
    assign o_wr.we   = accept && is_opaque;
    assign o_wr.addr = {r_wbank, r_lc};
    assign o_wr.data = i_pix.pixel;
endmodule

/* sv/trle_cmdq.sv */
// Small command FIFO between the front end and the byte sequencer.
// Uses trle_pkg for the command type and depth.
module trle_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trle_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output trle_pkg::t_cmd o_head,
    output logic           o_full,
    output logic           o_empty
);
    import trle_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr;
    logic [CMDQ_PTR_W-1:0] r_rptr;
    logic [CMDQ_PTR_W:0]   r_count;

    assign o_full  = (r_count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + CMDQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + CMDQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (CMDQ_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (CMDQ_PTR_W+1)'(1);
            end
        end
    end
endmodule

/* sv/trle_seq.sv */
// Back end sequencer: expands each command into a byte stream, one byte
// a cycle unless stalled, reading literals from the store. Uses trle_pkg.
module trle_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmdq_empty,
    input  trle_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output trle_pkg::t_ram_rd          o_rd,
    input  logic [trle_pkg::PIXEL_W-1:0] i_rdata,
    output trle_pkg::t_bank_rel        o_rel,
    output trle_pkg::t_byte            o_byte,
    input  logic                       i_byte_ready
);
    import trle_pkg::*;

    t_seq_state           r_state, n_state;
    t_cmd                 r_cmd;
    logic [LIT_IDX_W-1:0] r_idx;

    // Byte stage: value is either a constant or the registered store read
    logic                 r_bv;
    logic                 r_bmem;
    logic [PIXEL_W-1:0]   r_bconst;
    logic                 r_blast;

    logic                 adv;
    logic                 idx_last;
    t_seq_state           start_state;
    t_seq_state           after_skip;
    t_seq_state           after_lit;

    logic                 op_valid;
    logic                 op_mem;
    logic [PIXEL_W-1:0]   op_const;
    logic                 op_last;

    assign adv      = !r_bv || i_byte_ready;
    assign idx_last = ((r_idx + LIT_IDX_W'(1)) == r_cmd.lit_cnt);

    // Section order within one command
    always_comb begin
        if (i_cmd.skip_first && i_cmd.skip_v) begin
            start_state = SEQ_SKIP_HDR;
        end else if (i_cmd.lit_v) begin
            start_state = SEQ_LIT_CODE;
        end else if (i_cmd.skip_v) begin
            start_state = SEQ_SKIP_HDR;
        end else begin
            start_state = SEQ_ROW_END;
        end
        if (r_cmd.skip_first && r_cmd.lit_v) begin
            after_skip = SEQ_LIT_CODE;
        end else if (r_cmd.row_end) begin
            after_skip = SEQ_ROW_END;
        end else begin
            after_skip = SEQ_IDLE;
        end
        if (!r_cmd.skip_first && r_cmd.skip_v) begin
            after_lit = SEQ_SKIP_HDR;
        end else if (r_cmd.row_end) begin
            after_lit = SEQ_ROW_END;
        end else begin
            after_lit = SEQ_IDLE;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (!i_cmdq_empty) begin
                    n_state = start_state;
                end
            end
            SEQ_SKIP_HDR: begin
                if (adv) begin
                    n_state = SEQ_SKIP_LEN;
                end
            end
            SEQ_SKIP_LEN: begin
                if (adv) begin
                    n_state = after_skip;
                end
            end
            SEQ_LIT_CODE: begin
                if (adv) begin
                    n_state = SEQ_LIT_DATA;
                end
            end
            SEQ_LIT_DATA: begin
                if (adv && idx_last) begin
                    n_state = after_lit;
                end
            end
            SEQ_ROW_END: begin
                if (adv) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Byte ops, store reads and bank release
    always_comb begin
        o_pop       = 1'b0;
        op_valid    = 1'b0;
        op_mem      = 1'b0;
        op_const    = ROW_END_CODE;
        op_last     = 1'b0;
        o_rd.re     = 1'b0;
        o_rd.addr   = {r_cmd.lit_bank, r_idx};
        o_rel.valid = 1'b0;
        o_rel.bank  = r_cmd.lit_bank;
        unique case (r_state)
            SEQ_IDLE: begin
                o_pop = !i_cmdq_empty;
            end
            SEQ_SKIP_HDR: begin
                op_valid = 1'b1;
                op_const = SKIP_CODE;
            end
            SEQ_SKIP_LEN: begin
                op_valid = 1'b1;
                op_const = r_cmd.skip_len;
                op_last  = (after_skip == SEQ_IDLE);
            end
            SEQ_LIT_CODE: begin
                op_valid = 1'b1;
                op_const = {r_cmd.lit_cnt, 1'b1};
            end
            SEQ_LIT_DATA: begin
                op_valid    = 1'b1;
                op_mem      = 1'b1;
                op_last     = idx_last && (after_lit == SEQ_IDLE);
                o_rd.re     = adv;
                o_rel.valid = adv && idx_last;
            end
            SEQ_ROW_END: begin
                op_valid = 1'b1;
                op_const = ROW_END_CODE;
                op_last  = 1'b1;
            end
            default: begin
                op_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_bv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_bv <= op_valid;
            end
        end
    end

    // Command, index and byte stage payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == SEQ_LIT_CODE && adv) begin
            r_idx <= '0;
        end else if (r_state == SEQ_LIT_DATA && adv) begin
            r_idx <= r_idx + LIT_IDX_W'(1);
        end
        if (adv) begin
            r_bmem   <= op_mem;
            r_bconst <= op_const;
            r_blast  <= op_last;
        end
    end

    assign o_byte.valid = r_bv;
    assign o_byte.value = r_bmem ? i_rdata : r_bconst;
    assign o_byte.last  = r_blast;
endmodule

/* sv/trle_pack.sv */
// Packer: gathers bytes into result words and holds them in the output
// register. Uses trle_pkg, trle_word_if.
module trle_pack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trle_pkg::t_byte  i_byte,
    output logic             o_byte_ready,
    trle_word_if.source      o_word
);
    import trle_pkg::*;

    logic [PACK_W-1:0]       r_acc;
    logic [BYTE_COUNT_W-1:0] r_acc_cnt;

    logic                    r_ov;
    logic [PACK_W-1:0]       r_word;
    logic [BYTE_COUNT_W-1:0] r_cnt;
    logic                    r_last;

    logic                    out_free;
    logic                    take;
    logic                    emit;
    logic [BYTE_COUNT_W-1:0] cnt_inc;
    logic [PACK_W-1:0]       word_next;

    assign out_free     = !r_ov || o_word.ready;
    assign cnt_inc      = r_acc_cnt + BYTE_COUNT_W'(1);
    assign emit         = (cnt_inc == BYTE_COUNT_W'(BYTES_PER_RESULT)) || i_byte.last;
    assign o_byte_ready = !emit || out_free;
    assign take         = i_byte.valid && o_byte_ready;

    // Drop the byte into its lane
    always_comb begin
        word_next = r_acc;
        for (int j = 0; j < BYTE_LANES; j++) begin
            if (BYTE_COUNT_W'(j) == r_acc_cnt) begin
                word_next[j*PIXEL_W +: PIXEL_W] = i_byte.value;
            end
        end
    end

    // Control: fill level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt <= '0;
            r_ov      <= 1'b0;
            r_acc     <= '0;
        end else begin
            if (take && emit) begin
                r_acc_cnt <= '0;
                r_acc     <= '0;
                r_ov      <= 1'b1;
            end else begin
                if (take) begin
                    r_acc_cnt <= cnt_inc;
                    r_acc     <= word_next;
                end
                if (o_word.ready) begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_word <= word_next;
            r_cnt  <= cnt_inc;
            r_last <= i_byte.last;
        end
    end

    assign o_word.valid        = r_ov;
    assign o_word.packed_bytes = r_word;
    assign o_word.byte_count   = r_cnt;
    assign o_word.last         = r_last;
endmodule

/* sv/transparent_run_length_encoder.sv */
// Transparent run-length encoder for 8-bit sprite rows.
// Channels: i_pix takes one pixel (pixel, row_end) per beat; 0xFF is
// transparent. o_word gives result words of up to eight encoded bytes,
// first byte in bits 7..0, byte_count valid bytes, last on the final word
// of each pixel. Pixels that close no run give no word.
// Encoding: opaque run of n -> 2n+1 then the n pixels; transparent run of
// n -> 1, n; each row ends with 0.
// Throughput: the front end takes one pixel a cycle while its four-entry
// command queue has room. The back end sequencer emits one byte a cycle
// while the packer takes bytes, and passes through an idle state between
// commands; opaque pixels are held in a two-bank store, and between
// runs no pixel is taken until the bank to be written is free.
// Reset: synchronous, active low; clears all run state, no clearing pass.
// A stalled o_word holds its word; the back end and then the front end
// fill up and drop i_pix.ready.
// Uses trle_pkg, trle_if, trle_ram, trle_front, trle_cmdq, trle_seq, trle_pack.
module transparent_run_length_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trle_pix_if.sink    i_pix,
    trle_word_if.source o_word
);
    import trle_pkg::*;

    logic                cmdq_full;
    logic                cmdq_empty;
    logic                push;
    logic                pop;
    t_cmd                cmd_in;
    t_cmd                cmd_head;
    t_ram_wr             ram_wr;
    t_ram_rd             ram_rd;
    logic [PIXEL_W-1:0]  ram_rdata;
    t_bank_rel           rel;
    t_byte               seq_byte;
    logic                byte_ready;

    trle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cmdq_full (cmdq_full),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .o_wr        (ram_wr),
        .i_rel       (rel)
    );

    trle_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (ram_rd.re),
        .i_raddr (ram_rd.addr),
        .o_rdata (ram_rdata)
    );

    trle_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_full  (cmdq_full),
        .o_empty (cmdq_empty)
    );

    trle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmdq_empty (cmdq_empty),
        .i_cmd        (cmd_head),
        .o_pop        (pop),
        .o_rd         (ram_rd),
        .i_rdata      (ram_rdata),
        .o_rel        (rel),
        .o_byte       (seq_byte),
        .i_byte_ready (byte_ready)
    );

    trle_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (seq_byte),
        .o_byte_ready (byte_ready),
        .o_word       (o_word)
    );

`ifndef SYNTHESIS
    // Queue never written while full
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !cmdq_full)
        else $error("command queue overflow");

    // Queue never read while empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> !cmdq_empty)
        else $error("command queue underflow");

    // A literal close always carries at least one pixel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && cmd_in.lit_v) |-> (cmd_in.lit_cnt != '0))
        else $error("empty literal run issued");

    // Result words carry between one and a full word of bytes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.byte_count != '0 &&
                          o_word.byte_count <= BYTE_COUNT_W'(BYTES_PER_RESULT)))
        else $error("bad byte count on result word");
`endif
endmodule
